FILE: design/hbe_pkg.sv
`default_nettype none
package hbe_pkg;

  // block geometry
  localparam int BlockCoeffs = 64;
  localparam logic [5:0] LastPos = 6'(BlockCoeffs - 1);
  localparam logic [5:0] RunMax = 6'd63;
  localparam logic [5:0] ZrlRun = 6'd16;

  // symbol and byte constants
  localparam logic [7:0] ZrlSym = 8'hF0;
  localparam logic [7:0] EobSym = 8'h00;
  localparam logic [7:0] FfByte = 8'hFF;
  localparam logic [7:0] ZeroByte = 8'h00;
  localparam logic [7:0] EoiByte = 8'hD9;
  localparam logic [15:0] PadCode = 16'h007F;

  // item opcodes
  typedef enum logic [1:0] {
    OP_CODE    = 2'd0,
    OP_FINISH  = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  // source of the bits for one send
  typedef enum logic [2:0] {
    SEL_DC  = 3'd0,
    SEL_AC  = 3'd1,
    SEL_ZRL = 3'd2,
    SEL_EOB = 3'd3,
    SEL_MAG = 3'd4,
    SEL_PAD = 3'd5
  } sel_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic calc;
    logic dc_update;
    logic run_inc;
    logic run_clr;
    logic run_zrl;
    logic send;
    sel_e sel;
    logic drain;
    logic push_raw;
    logic raw_eoi;
    logic flush;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic comp_ok;
    logic pos_dc;
    logic pos_end;
    logic coef_zero;
    logic run_gt;
    logic drain_needed;
    logic can_push;
    logic hold_vld;
    logic out_free;
  } status_t;

  // code table entry: length in [20:16], code in [15:0]
  typedef logic [20:0] rom_t [256];

  localparam logic [1:0] TblDcY = 2'd0;
  localparam logic [1:0] TblDcC = 2'd1;
  localparam logic [1:0] TblAcY = 2'd2;
  localparam logic [1:0] TblAcC = 2'd3;

  localparam logic [7:0] LENS_DC_Y [16] = '{0,1,5,1,1,1,1,1,1,0,0,0,0,0,0,0};
  localparam logic [7:0] LENS_DC_C [16] = '{0,3,1,1,1,1,1,1,1,1,1,0,0,0,0,0};
  localparam logic [7:0] LENS_AC_Y [16] = '{0,2,1,3,3,2,4,3,5,5,4,4,0,0,1,8'h7d};
  localparam logic [7:0] LENS_AC_C [16] = '{0,2,1,2,4,4,3,4,7,5,4,4,0,1,2,8'h77};

  localparam logic [7:0] SYMS_AC_Y [162] = '{
    8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
    8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,8'h42,8'hb1,8'hc1,
    8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,
    8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
    8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
    8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
    8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,
    8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
    8'hd9,8'hda,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,
    8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

  localparam logic [7:0] SYMS_AC_C [162] = '{
    8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,
    8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'ha1,8'hb1,8'hc1,8'h09,
    8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,8'h0a,8'h16,8'h24,8'h34,8'he1,8'h25,
    8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h35,8'h36,8'h37,8'h38,
    8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,
    8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,
    8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
    8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,
    8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,
    8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,
    8'hd7,8'hd8,8'hd9,8'hda,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,
    8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

  // canonical code assignment, evaluated at elaboration only
  function automatic rom_t build_rom(input logic [1:0] tid);
    rom_t r;
    logic [31:0] code;
    logic [7:0] k;
    logic [7:0] n;
    logic [7:0] s;
    r = '{default: '0};
    code = '0;
    k = '0;
    for (int l = 1; l <= 16; l++) begin
      case (tid)
        TblDcY:  n = LENS_DC_Y[l-1];
        TblDcC:  n = LENS_DC_C[l-1];
        TblAcY:  n = LENS_AC_Y[l-1];
        default: n = LENS_AC_C[l-1];
      endcase
      for (int j = 0; j < int'(n); j++) begin
        case (tid)
          TblAcY:  s = SYMS_AC_Y[k];
          TblAcC:  s = SYMS_AC_C[k];
          default: s = k;
        endcase
        r[s] = {5'(l), code[15:0]};
        code = code + 32'd1;
        k = k + 8'd1;
      end
      code = code << 1;
    end
    return r;
  endfunction

  localparam rom_t RomDcY = build_rom(TblDcY);
  localparam rom_t RomDcC = build_rom(TblDcC);
  localparam rom_t RomAcY = build_rom(TblAcY);
  localparam rom_t RomAcC = build_rom(TblAcC);

endpackage
`default_nettype wire

FILE: design/hbe_ctrl.sv
`default_nettype none
module hbe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hbe_pkg::status_t status_i,
  output hbe_pkg::cmd_t    cmd_o
);
  import hbe_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_DECODE  = 10'b0000000010,
    ST_ZRL     = 10'b0000000100,
    ST_SYM     = 10'b0000001000,
    ST_MAG     = 10'b0000010000,
    ST_EOB     = 10'b0000100000,
    ST_PAD     = 10'b0001000000,
    ST_MARK_FF = 10'b0010000000,
    ST_MARK_D9 = 10'b0100000000,
    ST_FLUSH   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic drain_step;

  // full bytes waiting in the accumulator go out before any new bits
  assign drain_step = status_i.drain_needed;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.sel = SEL_DC;
    in_ready_o = 1'b0;
    if (drain_step && state_q != ST_IDLE && state_q != ST_DECODE) begin
      cmd_o.drain = status_i.can_push;
    end else begin
      case (state_q)
        ST_IDLE: begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d = ST_DECODE;
          end
        end
        ST_DECODE: begin
          case (status_i.op)
            OP_RESTART: begin
              cmd_o.clear = 1'b1;
              state_d = ST_IDLE;
            end
            OP_FINISH: state_d = ST_PAD;
            OP_CODE: begin
              if (!status_i.comp_ok) begin
                state_d = ST_IDLE;
              end else if (status_i.pos_dc) begin
                cmd_o.calc = 1'b1;
                cmd_o.dc_update = 1'b1;
                cmd_o.run_clr = 1'b1;
                state_d = ST_SYM;
              end else if (status_i.coef_zero) begin
                if (status_i.pos_end) begin
                  state_d = ST_EOB;
                end else begin
                  cmd_o.run_inc = 1'b1;
                  state_d = ST_IDLE;
                end
              end else begin
                cmd_o.calc = 1'b1;
                state_d = ST_ZRL;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
        ST_ZRL: begin
          if (status_i.run_gt) begin
            cmd_o.send = 1'b1;
            cmd_o.sel = SEL_ZRL;
            cmd_o.run_zrl = 1'b1;
          end else begin
            state_d = ST_SYM;
          end
        end
        ST_SYM: begin
          cmd_o.send = 1'b1;
          cmd_o.sel = status_i.pos_dc ? SEL_DC : SEL_AC;
          state_d = ST_MAG;
        end
        ST_MAG: begin
          cmd_o.send = 1'b1;
          cmd_o.sel = SEL_MAG;
          cmd_o.run_clr = 1'b1;
          state_d = ST_FLUSH;
        end
        ST_EOB: begin
          cmd_o.send = 1'b1;
          cmd_o.sel = SEL_EOB;
          cmd_o.run_clr = 1'b1;
          state_d = ST_FLUSH;
        end
        ST_PAD: begin
          cmd_o.send = 1'b1;
          cmd_o.sel = SEL_PAD;
          state_d = ST_MARK_FF;
        end
        ST_MARK_FF: begin
          if (status_i.can_push) begin
            cmd_o.push_raw = 1'b1;
            state_d = ST_MARK_D9;
          end
        end
        ST_MARK_D9: begin
          if (status_i.can_push) begin
            cmd_o.push_raw = 1'b1;
            cmd_o.raw_eoi = 1'b1;
            state_d = ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!status_i.hold_vld) begin
            state_d = ST_IDLE;
          end else if (status_i.out_free) begin
            cmd_o.flush = 1'b1;
            state_d = ST_IDLE;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/hbe_datapath.sv
`default_nettype none
module hbe_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hbe_pkg::cmd_t      cmd_i,
  output hbe_pkg::status_t   status_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [10:0] coefficient_i,
  input  logic [1:0]         component_i,
  input  logic [5:0]         position_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o,
  output logic [23:0]        out_total_o
);
  import hbe_pkg::*;

  // latched item
  logic [1:0] op_q;
  logic signed [10:0] coef_q;
  logic [1:0] comp_q;
  logic [5:0] pos_q;

  // coder state
  logic signed [10:0] pred_q [3];
  logic [5:0] run_q, run_d;
  logic [22:0] acc_q, acc_d;
  logic [4:0] cnt_q, cnt_d;
  logic [23:0] total_q, total_d;
  logic stuff_q, stuff_d;
  logic [10:0] mag_q;
  logic [3:0] cat_q;

  // byte hold and output register
  logic hold_vld_q, hold_vld_d;
  logic [7:0] hold_byte_q;
  logic [23:0] hold_total_q;
  logic out_vld_q, out_vld_d;
  logic [7:0] out_byte_q;
  logic out_last_q;
  logic [23:0] out_total_q;

  logic signed [10:0] pred_cur, ac_v;
  logic signed [11:0] diff, val;
  logic [11:0] abs_v, mag_v;
  logic [3:0] cat_v;
  logic chroma;
  logic [7:0] idx;
  logic [20:0] entry;
  logic [15:0] code, mask;
  logic [4:0] len;
  logic [22:0] acc_send;
  logic [4:0] cnt_dr;
  logic [7:0] byte_dr;
  logic [22:0] mask_dr;
  logic out_free, can_push, push, move;
  logic [7:0] push_byte;

  // value to code: dc difference or clamped ac value
  always_comb begin
    case (comp_q)
      2'd0:    pred_cur = pred_q[0];
      2'd1:    pred_cur = pred_q[1];
      default: pred_cur = pred_q[2];
    endcase
    diff = {coef_q[10], coef_q} - {pred_cur[10], pred_cur};
    ac_v = (coef_q == 11'sh400) ? 11'sh401 : coef_q;
    val = (pos_q == '0) ? diff : {ac_v[10], ac_v};
    abs_v = val[11] ? -val : val;
    mag_v = val[11] ? val - 12'sd1 : val;
    cat_v = '0;
    for (int i = 0; i < 11; i++) begin
      if (abs_v[i]) cat_v = 4'(i + 1);
    end
  end

  // code and length of the current send
  assign chroma = (comp_q != 2'd0);
  always_comb begin
    case (cmd_i.sel)
      SEL_DC:  idx = {4'd0, cat_q};
      SEL_AC:  idx = {run_q[3:0], cat_q};
      SEL_ZRL: idx = ZrlSym;
      default: idx = EobSym;
    endcase
    if (cmd_i.sel == SEL_DC) begin
      entry = chroma ? RomDcC[idx] : RomDcY[idx];
    end else begin
      entry = chroma ? RomAcC[idx] : RomAcY[idx];
    end
    case (cmd_i.sel)
      SEL_MAG: begin
        code = {5'd0, mag_q};
        len = {1'b0, cat_q};
      end
      SEL_PAD: begin
        code = PadCode;
        len = (cnt_q == '0) ? 5'd0 : 5'd8 - cnt_q;
      end
      default: begin
        code = entry[15:0];
        len = entry[20:16];
      end
    endcase
    mask = 16'((17'd1 << len) - 17'd1);
    acc_send = (acc_q << len) | {7'd0, code & mask};
  end

  // top byte of the accumulator
  assign cnt_dr = cnt_q - 5'd8;
  assign byte_dr = 8'(acc_q >> cnt_dr);
  assign mask_dr = 23'((24'd1 << cnt_dr) - 24'd1);

  // byte movement
  assign out_free = !out_vld_q || out_ready_i;
  assign can_push = !hold_vld_q || out_free;
  assign push = cmd_i.drain || cmd_i.push_raw;
  assign move = hold_vld_q && (push || cmd_i.flush);
  always_comb begin
    if (cmd_i.push_raw) begin
      push_byte = cmd_i.raw_eoi ? EoiByte : FfByte;
    end else if (stuff_q) begin
      push_byte = ZeroByte;
    end else begin
      push_byte = byte_dr;
    end
  end

  // next values of the coder state
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    stuff_d = stuff_q;
    run_d = run_q;
    total_d = total_q;
    if (cmd_i.send) begin
      acc_d = acc_send;
      cnt_d = cnt_q + len;
    end else if (cmd_i.drain) begin
      if (stuff_q) begin
        stuff_d = 1'b0;
      end else begin
        acc_d = acc_q & mask_dr;
        cnt_d = cnt_dr;
        stuff_d = (byte_dr == FfByte);
      end
    end
    if (push && total_q != '1) total_d = total_q + 24'd1;
    if (cmd_i.run_clr) begin
      run_d = '0;
    end else if (cmd_i.run_zrl) begin
      run_d = run_q - ZrlRun;
    end else if (cmd_i.run_inc && run_q != RunMax) begin
      run_d = run_q + 6'd1;
    end
    if (cmd_i.clear) begin
      acc_d = '0;
      cnt_d = '0;
      stuff_d = 1'b0;
      run_d = '0;
      total_d = '0;
    end
  end

  // output register next valid
  always_comb begin
    if (move) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
    if (push) begin
      hold_vld_d = 1'b1;
    end else if (cmd_i.flush) begin
      hold_vld_d = 1'b0;
    end else begin
      hold_vld_d = hold_vld_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      stuff_q <= 1'b0;
      run_q <= '0;
      total_q <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      pred_q <= '{default: '0};
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      stuff_q <= stuff_d;
      run_q <= run_d;
      total_q <= total_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q <= out_vld_d;
      if (cmd_i.clear) begin
        pred_q <= '{default: '0};
      end else if (cmd_i.dc_update) begin
        case (comp_q)
          2'd0:    pred_q[0] <= coef_q;
          2'd1:    pred_q[1] <= coef_q;
          default: pred_q[2] <= coef_q;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i;
      coef_q <= coefficient_i;
      comp_q <= component_i;
      pos_q <= position_i;
    end
    if (cmd_i.calc) begin
      mag_q <= mag_v[10:0];
      cat_q <= cat_v;
    end
    if (push) begin
      hold_byte_q <= push_byte;
      hold_total_q <= total_d;
    end
    if (move) begin
      out_byte_q <= hold_byte_q;
      out_total_q <= hold_total_q;
      out_last_q <= cmd_i.flush;
    end
  end

  // status to the controller
  always_comb begin
    status_o.op = op_q;
    status_o.comp_ok = (comp_q != 2'd3);
    status_o.pos_dc = (pos_q == '0);
    status_o.pos_end = (pos_q == LastPos);
    status_o.coef_zero = (coef_q == '0);
    status_o.run_gt = (run_q >= ZrlRun);
    status_o.drain_needed = stuff_q || (cnt_q >= 5'd8);
    status_o.can_push = can_push;
    status_o.hold_vld = hold_vld_q;
    status_o.out_free = out_free;
  end

  assign out_valid_o = out_vld_q;
  assign out_byte_o = out_byte_q;
  assign out_last_o = out_last_q;
  assign out_total_o = out_total_q;

endmodule
`default_nettype wire

FILE: design/jpeg_huffman_block_encoder.sv
// A request is taken in idle and decoded in the next cycle; a zero coefficient inside a
// block only counts the run, an end-of-block sends EOB, a dc value its size symbol and
// magnitude, a nonzero ac value zero-run escapes, symbol and magnitude, a finish the pad
// bits and the FF D9 marker; bytes and stuffed zeros drain between sends. A new request
// waits until the last is done. Bytes pass a one-byte hold and an output register; a
// byte leaves the hold when the next one is formed or when a request that sent bits ends.
// Reset (rst_ni low, asynchronous) clears predictors, run, bit buffer and byte count.
`default_nettype none
module jpeg_huffman_block_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // coefficient[10:0], position[16:11], zero fill
  input  logic [3:0]  s_axis_tuser_i,  // opcode[1:0], component[3:2]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // out_byte[7:0], byte_total[31:8]
  output logic        m_axis_tlast_o   // is_last
);
  import hbe_pkg::*;

  cmd_t cmd;
  status_t status;
  logic [7:0] out_byte;
  logic [23:0] out_total;

  hbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hbe_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .opcode_i      (s_axis_tuser_i[1:0]),
    .coefficient_i (s_axis_tdata_i[10:0]),
    .component_i   (s_axis_tuser_i[3:2]),
    .position_i    (s_axis_tdata_i[16:11]),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_byte_o    (out_byte),
    .out_last_o    (m_axis_tlast_o),
    .out_total_o   (out_total)
  );

  // pack the result request
  assign m_axis_tdata_o = {out_total, out_byte};

endmodule
`default_nettype wire
